### src/dll_pkg.sv
// Shared types and command codes for the doubly linked list manager.
package dll_pkg;

   // Command codes carried on req_command.
   localparam logic [3:0] CMD_INS_AFTER  = 4'd0;
   localparam logic [3:0] CMD_INS_BEFORE = 4'd1;
   localparam logic [3:0] CMD_APPEND     = 4'd2;
   localparam logic [3:0] CMD_PREPEND    = 4'd3;
   localparam logic [3:0] CMD_REMOVE     = 4'd4;
   localparam logic [3:0] CMD_POP        = 4'd5;
   localparam logic [3:0] CMD_FIRST      = 4'd6;
   localparam logic [3:0] CMD_LAST       = 4'd7;
   localparam logic [3:0] CMD_NEXT       = 4'd8;
   localparam logic [3:0] CMD_PREV       = 4'd9;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP1,
      ST_STEP2,
      ST_HOLD
   } state_type;

   // Link operation decoded from a command.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_AFTER,
      ACT_BEFORE,
      ACT_UNLINK,
      ACT_NEXT,
      ACT_PREV
   } act_type;

   // Access controls for the two link memories.
   typedef struct packed {
      logic rd_en;
      logic f_we;
      logic b_we;
   } mem_ctl_type;

endpackage

### src/dll_link_store.sv
// Forward and backward link memories with the head sentinel held in registers.
module dll_link_store import dll_pkg::*; #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mem_ctl_type              ctl,
   input  logic [$clog2(DEPTH)-1:0] f_addr,
   input  logic [$clog2(DEPTH)-1:0] f_wdata,
   input  logic [$clog2(DEPTH)-1:0] b_addr,
   input  logic [$clog2(DEPTH)-1:0] b_wdata,
   output logic [$clog2(DEPTH)-1:0] f_rdata,
   output logic [$clog2(DEPTH)-1:0] b_rdata,
   output logic [$clog2(DEPTH)-1:0] head_fwd,
   output logic [$clog2(DEPTH)-1:0] head_bwd
);

   localparam int AW = $clog2(DEPTH);

   logic [AW-1:0] fwd_mem [DEPTH];
   logic [AW-1:0] bwd_mem [DEPTH];
   logic [AW-1:0] fwd_q_ff;
   logic [AW-1:0] bwd_q_ff;
   logic          f_zero_ff;
   logic          b_zero_ff;
   logic [AW-1:0] head_fwd_ff;
   logic [AW-1:0] head_bwd_ff;

   // Entry zero lives in the head registers so that reset empties the list.
   always_ff @(posedge clock) begin
      if (ctl.f_we && f_addr != '0) begin
         fwd_mem[f_addr] <= f_wdata;
      end
      if (ctl.rd_en) begin
         fwd_q_ff  <= fwd_mem[f_addr];
         f_zero_ff <= (f_addr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.b_we && b_addr != '0) begin
         bwd_mem[b_addr] <= b_wdata;
      end
      if (ctl.rd_en) begin
         bwd_q_ff  <= bwd_mem[b_addr];
         b_zero_ff <= (b_addr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_fwd_ff <= '0;
         head_bwd_ff <= '0;
      end else begin
         if (ctl.f_we && f_addr == '0) begin
            head_fwd_ff <= f_wdata;
         end
         if (ctl.b_we && b_addr == '0) begin
            head_bwd_ff <= b_wdata;
         end
      end
   end

   assign f_rdata  = f_zero_ff ? head_fwd_ff : fwd_q_ff;
   assign b_rdata  = b_zero_ff ? head_bwd_ff : bwd_q_ff;
   assign head_fwd = head_fwd_ff;
   assign head_bwd = head_bwd_ff;

   // Each memory has a single port, so a read never shares a cycle with a write.
   assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |-> !(ctl.f_we || ctl.b_we))
      else $error("link memory read and write in the same cycle");

   assert property (@(posedge clock) disable iff (reset)
      (ctl.f_we && f_addr == '0) |=> (head_fwd == $past(f_wdata)))
      else $error("head forward link not updated");

   assert property (@(posedge clock) disable iff (reset)
      (ctl.b_we && b_addr == '0) |=> (head_bwd == $past(b_wdata)))
      else $error("head backward link not updated");

endmodule

### src/doubly_linked_list_manager.sv
// Top level: command sequencer for a circular doubly linked list over a node pool.
// A new request is taken only in the idle state, once the previous one is done: the link
// memories are read at the transfer, then written in the first and second write steps,
// because each memory has one port. The response is loaded from the second write step,
// or from a hold state while the consumer stalls, and nothing else is accepted until it is loaded.
// Reset clears the head links (empty list) and the control state; no clearing pass.
module doubly_linked_list_manager import dll_pkg::*; #(
   parameter int MAX_NODES = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [3:0] req_command,
   input  logic [7:0] req_anchor_node,
   input  logic [7:0] req_item_node,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_result_node,
   output logic       rsp_found
);

   localparam int DEPTH = (MAX_NODES < 255) ? MAX_NODES + 1 : 256;
   localparam int AW    = $clog2(DEPTH);

   typedef logic [AW-1:0] idx_type;

   state_type   state_ff, state_in;
   act_type     act_ff, act_in, act_dec;
   idx_type     node_ff, node_in, node_dec;
   idx_type     at_ff, at_in, at_dec;
   idx_type     link_ff, link_in;
   idx_type     res_ff, res_in, res_dec;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_node_ff;
   logic        rsp_found_ff;
   logic        rsp_load;
   logic        rsp_free;
   logic        req_accept;

   mem_ctl_type mem_ctl;
   idx_type     f_addr, f_wdata, b_addr, b_wdata;
   idx_type     f_rdata, b_rdata, head_fwd, head_bwd;

   logic        empty;
   logic        item_ok, item_ins, anchor_ok;
   idx_type     item_idx, anchor_idx;

   dll_link_store #(
      .DEPTH(DEPTH)
   ) u_links (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mem_ctl),
      .f_addr   (f_addr),
      .f_wdata  (f_wdata),
      .b_addr   (b_addr),
      .b_wdata  (b_wdata),
      .f_rdata  (f_rdata),
      .b_rdata  (b_rdata),
      .head_fwd (head_fwd),
      .head_bwd (head_bwd)
   );

   assign empty      = (head_fwd == '0);
   assign item_ok    = int'(req_item_node) <= MAX_NODES;
   assign anchor_ok  = int'(req_anchor_node) <= MAX_NODES;
   assign item_ins   = item_ok && (req_item_node != 8'd0);
   assign item_idx   = AW'(req_item_node);
   assign anchor_idx = AW'(req_anchor_node);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Command decode, using the head links as they stand at the transfer.
   always_comb begin
      act_dec  = ACT_NONE;
      node_dec = item_idx;
      at_dec   = '0;
      res_dec  = '0;
      case (req_command)
         CMD_INS_AFTER: begin
            if (item_ins && anchor_ok) begin
               act_dec = ACT_AFTER;
               at_dec  = empty ? '0 : anchor_idx;
            end
         end
         CMD_INS_BEFORE: begin
            if (item_ins && anchor_ok) begin
               act_dec = ACT_BEFORE;
               at_dec  = empty ? '0 : anchor_idx;
            end
         end
         CMD_APPEND: begin
            if (item_ins) begin
               act_dec = ACT_AFTER;
               at_dec  = empty ? '0 : head_bwd;
            end
         end
         CMD_PREPEND: begin
            if (item_ins) begin
               act_dec = ACT_BEFORE;
               at_dec  = empty ? '0 : head_fwd;
            end
         end
         CMD_REMOVE: begin
            if (item_ins) begin
               act_dec = ACT_UNLINK;
            end
         end
         CMD_POP: begin
            if (!empty) begin
               act_dec  = ACT_UNLINK;
               node_dec = head_bwd;
               res_dec  = head_bwd;
            end
         end
         CMD_FIRST: begin
            if (!empty) begin
               res_dec = head_fwd;
            end
         end
         CMD_LAST: begin
            if (!empty) begin
               res_dec = head_bwd;
            end
         end
         CMD_NEXT: begin
            if (item_ok && req_item_node != 8'(head_bwd)) begin
               act_dec = ACT_NEXT;
            end
         end
         CMD_PREV: begin
            if (item_ok && req_item_node != 8'(head_fwd)) begin
               act_dec = ACT_PREV;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      node_ff <= node_in;
      at_ff   <= at_in;
      link_ff <= link_in;
      res_ff  <= res_in;
      if (rsp_load) begin
         rsp_node_ff  <= 8'(res_ff);
         rsp_found_ff <= (res_ff != '0);
      end
   end

   // Sequencer: read at the transfer, first link writes, second link writes, then hold while the response is stalled.
   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      node_in   = node_ff;
      at_in     = at_ff;
      link_in   = link_ff;
      res_in    = res_ff;
      req_stall = 1'b1;
      rsp_load  = 1'b0;
      mem_ctl   = '0;
      f_addr    = '0;
      f_wdata   = '0;
      b_addr    = '0;
      b_wdata   = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            f_addr    = (act_dec == ACT_AFTER) ? at_dec : node_dec;
            b_addr    = (act_dec == ACT_BEFORE) ? at_dec : node_dec;
            if (req_valid) begin
               mem_ctl.rd_en = 1'b1;
               act_in        = act_dec;
               node_in       = node_dec;
               at_in         = at_dec;
               res_in        = res_dec;
               state_in      = ST_STEP1;
            end
         end
         ST_STEP1: begin
            case (act_ff)
               ACT_AFTER: begin
                  mem_ctl.f_we = 1'b1;
                  f_addr       = node_ff;
                  f_wdata      = f_rdata;
                  mem_ctl.b_we = 1'b1;
                  b_addr       = node_ff;
                  b_wdata      = at_ff;
                  link_in      = f_rdata;
               end
               ACT_BEFORE: begin
                  mem_ctl.f_we = 1'b1;
                  f_addr       = node_ff;
                  f_wdata      = at_ff;
                  mem_ctl.b_we = 1'b1;
                  b_addr       = node_ff;
                  b_wdata      = b_rdata;
                  link_in      = b_rdata;
               end
               ACT_UNLINK: begin
                  mem_ctl.f_we = 1'b1;
                  f_addr       = b_rdata;
                  f_wdata      = f_rdata;
                  mem_ctl.b_we = 1'b1;
                  b_addr       = f_rdata;
                  b_wdata      = b_rdata;
               end
               ACT_NEXT: begin
                  res_in = f_rdata;
               end
               ACT_PREV: begin
                  res_in = b_rdata;
               end
               default: begin
               end
            endcase
            state_in = ST_STEP2;
         end
         ST_STEP2: begin
            case (act_ff)
               ACT_AFTER: begin
                  mem_ctl.f_we = 1'b1;
                  f_addr       = at_ff;
                  f_wdata      = node_ff;
                  mem_ctl.b_we = 1'b1;
                  b_addr       = link_ff;
                  b_wdata      = node_ff;
               end
               ACT_BEFORE: begin
                  mem_ctl.f_we = 1'b1;
                  f_addr       = link_ff;
                  f_wdata      = node_ff;
                  mem_ctl.b_we = 1'b1;
                  b_addr       = at_ff;
                  b_wdata      = node_ff;
               end
               ACT_UNLINK: begin
                  mem_ctl.f_we = 1'b1;
                  f_addr       = node_ff;
                  mem_ctl.b_we = 1'b1;
                  b_addr       = node_ff;
               end
               default: begin
               end
            endcase
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in    = rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_node = rsp_node_ff;
   assign rsp_found       = rsp_found_ff;

   // Every request transfer reaches the response stage after the first and second write steps.
   assert property (@(posedge clock) disable iff (reset)
      req_accept |-> ##2 (rsp_load || state_in == ST_HOLD))
      else $error("request did not reach the response stage");

   // The links change only in the two write steps of a command.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_HOLD) |-> !(mem_ctl.f_we || mem_ctl.b_we))
      else $error("link write outside a write step");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_found == (rsp_result_node != 8'd0)))
      else $error("found flag disagrees with result node");

endmodule
